>>> design/bracket_balance_checker_defines.svh
// Assertion helpers for the bracket balance checker.
// Both macros sample on clk and are disabled while arst_n is low.
`ifndef BRACKET_BALANCE_CHECKER_DEFINES_SVH
`define BRACKET_BALANCE_CHECKER_DEFINES_SVH

// Consequent checked in the same cycle as the antecedent.
`define BBC_ASSERT_NOW(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("bbc: check failed");

// Consequent checked in the cycle after the antecedent.
`define BBC_ASSERT_NEXT(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("bbc: check failed");

`endif

>>> design/bbc_pkg.sv
`default_nettype none

package bbc_pkg;

	localparam int STACK_DEPTH = 256;
	localparam int ADDR_W      = $clog2(STACK_DEPTH);
	localparam int DEPTH_W     = $clog2(STACK_DEPTH + 1);

	// status codes
	localparam logic [2:0] ST_OK       = 3'd0;
	localparam logic [2:0] ST_MISMATCH = 3'd1;
	localparam logic [2:0] ST_EMPTY    = 3'd2;
	localparam logic [2:0] ST_UNCLOSED = 3'd3;
	localparam logic [2:0] ST_OVERFLOW = 3'd4;

	// bracket kinds as kept on the stack
	localparam logic [1:0] KIND_ROUND  = 2'd0;
	localparam logic [1:0] KIND_SQUARE = 2'd1;
	localparam logic [1:0] KIND_CURLY  = 2'd2;
	localparam logic [1:0] KIND_NONE   = 2'd3;

	localparam logic [7:0] CH_LROUND  = 8'h28;
	localparam logic [7:0] CH_RROUND  = 8'h29;
	localparam logic [7:0] CH_LSQUARE = 8'h5B;
	localparam logic [7:0] CH_RSQUARE = 8'h5D;
	localparam logic [7:0] CH_LCURLY  = 8'h7B;
	localparam logic [7:0] CH_RCURLY  = 8'h7D;

	typedef struct packed {
		logic       valid_res;
		logic [2:0] status;
	} res_t;

	function automatic logic [1:0] opener_kind(input logic [7:0] c);
		logic [1:0] k;
		case (c)
			CH_LROUND:  k = KIND_ROUND;
			CH_LSQUARE: k = KIND_SQUARE;
			CH_LCURLY:  k = KIND_CURLY;
			default:    k = KIND_NONE;
		endcase
		return k;
	endfunction

	function automatic logic [1:0] closer_kind(input logic [7:0] c);
		logic [1:0] k;
		case (c)
			CH_RROUND:  k = KIND_ROUND;
			CH_RSQUARE: k = KIND_SQUARE;
			CH_RCURLY:  k = KIND_CURLY;
			default:    k = KIND_NONE;
		endcase
		return k;
	endfunction

endpackage

`default_nettype wire

>>> design/bbc_stack_ram.sv
`default_nettype none

// Simple dual-port RAM, one write and one registered read per cycle.
module bbc_stack_ram #(
	parameter int DEPTH = 256,
	parameter int WIDTH = 2
) (
	input  wire logic                     clk,
	input  wire logic                     we,
	input  wire logic [$clog2(DEPTH)-1:0] waddr,
	input  wire logic [WIDTH-1:0]         wdata,
	input  wire logic [$clog2(DEPTH)-1:0] raddr,
	output logic      [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
	end

	always_ff @(posedge clk) begin
		rdata <= mem[raddr];
	end

endmodule

`default_nettype wire

>>> design/bbc_core.sv
`default_nettype none

// Stack engine. top_q caches stack[depth-1]; the RAM read port is always
// aimed at stack[depth_next-2], so the entry under the top is ready in the
// next cycle, in time for a pop in any following cycle.
module bbc_core (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        take,
	input  wire logic [7:0]  ch,
	input  wire logic        has_char,
	input  wire logic        last,
	output logic             res_v,
	output bbc_pkg::res_t    res
);

	import bbc_pkg::*;

	localparam logic [DEPTH_W-1:0] FULL = DEPTH_W'(STACK_DEPTH);
	localparam logic [DEPTH_W-1:0] TWO  = DEPTH_W'(2);

	logic [DEPTH_W-1:0] depth_q, depth_n;
	logic [2:0]         err_q, err_n;
	logic [1:0]         top_q, top_n;
	logic [1:0]         okind, ckind;
	logic [2:0]         st;
	logic               we;
	logic [ADDR_W-1:0]  waddr, raddr;
	logic [1:0]         under_top;

	assign okind = opener_kind(ch);
	assign ckind = closer_kind(ch);

	always_comb begin
		depth_n = depth_q;
		err_n   = err_q;
		top_n   = top_q;
		we      = 1'b0;
		waddr   = depth_q[ADDR_W-1:0];
		if (take && has_char && err_q == ST_OK) begin
			if (okind != KIND_NONE) begin
				if (depth_q == FULL) begin
					err_n = ST_OVERFLOW;
				end else begin
					we      = 1'b1;
					depth_n = depth_q + 1'b1;
					top_n   = okind;
				end
			end else if (ckind != KIND_NONE) begin
				if (depth_q == '0) begin
					err_n = ST_EMPTY;
				end else begin
					depth_n = depth_q - 1'b1;
					top_n   = under_top;
					if (top_q != ckind) begin
						err_n = ST_MISMATCH;
					end
				end
			end
		end

		st = err_n;
		if (st == ST_OK && depth_n != '0) begin
			st = ST_UNCLOSED;
		end
		res.status    = st;
		res.valid_res = (st == ST_OK);
		res_v         = take && last;

		if (take && last) begin
			depth_n = '0;
			err_n   = ST_OK;
		end
	end

	// below two entries the read is don't-care
	assign raddr = ADDR_W'(depth_n - TWO);

	bbc_stack_ram #(
		.DEPTH (STACK_DEPTH),
		.WIDTH (2)
	) u_ram (
		.clk   (clk),
		.we    (we),
		.waddr (waddr),
		.wdata (okind),
		.raddr (raddr),
		.rdata (under_top)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			depth_q <= '0;
			err_q   <= ST_OK;
		end else begin
			depth_q <= depth_n;
			err_q   <= err_n;
		end
	end

	always_ff @(posedge clk) begin
		top_q <= top_n;
	end

endmodule

`default_nettype wire

>>> design/bbc_out_buf.sv
`default_nettype none

// Output register plus one skid entry. Input stalls only when the skid
// entry is occupied.
module bbc_out_buf (
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire logic          res_v,
	input  wire bbc_pkg::res_t res,
	input  wire logic          out_stall,
	output logic               full,
	output logic               out_valid,
	output bbc_pkg::res_t      out_res
);

	import bbc_pkg::*;

	logic out_v_q;
	logic skid_v_q;
	res_t out_q;
	res_t skid_q;
	logic drain;

	assign drain = !out_v_q || !out_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_v_q  <= 1'b0;
			skid_v_q <= 1'b0;
		end else if (drain) begin
			out_v_q  <= skid_v_q || res_v;
			skid_v_q <= 1'b0;
		end else if (res_v) begin
			skid_v_q <= 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (drain) begin
			out_q <= skid_v_q ? skid_q : res;
		end else if (res_v) begin
			skid_q <= res;
		end
	end

	assign full      = skid_v_q;
	assign out_valid = out_v_q;
	assign out_res   = out_q;

endmodule

`default_nettype wire

>>> design/bracket_balance_checker.sv
`default_nettype none

// Bracket balance checker: takes one character beat per cycle while
// in_stall is low, with no gaps between strings. Openers ( [ { push onto
// a 256-entry stack of 2-bit kinds held in a single simple dual-port RAM;
// the top of stack is cached in a register and the RAM read port prefetches
// the entry beneath it, so back-to-back pops and pushes run at full rate.
// Each beat with last set yields one result beat, registered in the output
// buffer, carrying valid_res and status (0 ok, 1 mismatched closer, 2 closer
// on empty stack, 3 unclosed openers, 4 nesting deeper than the stack).
// Results sit in an output register with one skid entry behind it; in_stall
// rises only when both are full. The stack needs no clearing after reset.
module bracket_balance_checker (
	input  wire logic       clk,
	input  wire logic       arst_n,
	input  wire logic       in_valid,
	output logic            in_stall,
	input  wire logic [7:0] ch,
	input  wire logic       has_char,
	input  wire logic       last,
	output logic            out_valid,
	input  wire logic       out_stall,
	output logic            valid_res,
	output logic [2:0]      status
);

	import bbc_pkg::*;

	logic take;
	logic res_v;
	res_t res;
	res_t out_res;

	assign take = in_valid && !in_stall;

	bbc_core u_core (
		.clk      (clk),
		.arst_n   (arst_n),
		.take     (take),
		.ch       (ch),
		.has_char (has_char),
		.last     (last),
		.res_v    (res_v),
		.res      (res)
	);

	bbc_out_buf u_out (
		.clk       (clk),
		.arst_n    (arst_n),
		.res_v     (res_v),
		.res       (res),
		.out_stall (out_stall),
		.full      (in_stall),
		.out_valid (out_valid),
		.out_res   (out_res)
	);

	assign valid_res = out_res.valid_res;
	assign status    = out_res.status;

endmodule

`default_nettype wire

>>> design/bbc_checker.sv
`default_nettype none

`include "bracket_balance_checker_defines.svh"

module bbc_checker (
	input wire logic       clk,
	input wire logic       arst_n,
	input wire logic       in_valid,
	input wire logic       in_stall,
	input wire logic       last,
	input wire logic       out_valid,
	input wire logic       out_stall,
	input wire logic       valid_res,
	input wire logic [2:0] status
);

	import bbc_pkg::*;

	// stalled result beat holds
	`BBC_ASSERT_NEXT(a_out_hold, out_valid && out_stall, out_valid && $stable(status) && $stable(valid_res))

	`BBC_ASSERT_NOW(a_flag_matches_status, out_valid, valid_res == (status == ST_OK))

	`BBC_ASSERT_NOW(a_status_range, out_valid, status <= ST_OVERFLOW)

	// a fresh result only follows an accepted end-of-string beat
	`BBC_ASSERT_NOW(a_result_cause, $rose(out_valid), $past(in_valid && !in_stall && last))

endmodule

bind bracket_balance_checker bbc_checker u_bbc_checker (.*);

`default_nettype wire
